@@ hw/rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and a width helper for the rotation matrix to
// quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int QUAT_W = 16;

    // Which quaternion component is taken as the largest one
    typedef enum logic [1:0] {
        CASE_X,
        CASE_Y,
        CASE_Z,
        CASE_W
    } quat_case_t;

    // Status of the component queue between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Signed width of one unnormalized component for a given fraction width
    function automatic int comp_width(input int frac_bits);
        int base;
        begin
            base = (frac_bits > 17) ? frac_bits : 17;
            return base + 3;
        end
    endfunction

endpackage

@@ hw/rtl/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq_if
// Valid/ready channels: matrix words in, quaternion words out.
// ----------------------------------------------------------------------------
interface mat_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmq_pkg::ELEM_W-1:0]   m00;
    logic signed [rmq_pkg::ELEM_W-1:0]   m01;
    logic signed [rmq_pkg::ELEM_W-1:0]   m02;
    logic signed [rmq_pkg::ELEM_W-1:0]   m10;
    logic signed [rmq_pkg::ELEM_W-1:0]   m11;
    logic signed [rmq_pkg::ELEM_W-1:0]   m12;
    logic signed [rmq_pkg::ELEM_W-1:0]   m20;
    logic signed [rmq_pkg::ELEM_W-1:0]   m21;
    logic signed [rmq_pkg::ELEM_W-1:0]   m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmq_pkg::QUAT_W-1:0]   quat_x;
    logic signed [rmq_pkg::QUAT_W-1:0]   quat_y;
    logic signed [rmq_pkg::QUAT_W-1:0]   quat_z;
    logic signed [rmq_pkg::QUAT_W-1:0]   quat_w;
    logic                                degenerate;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                    input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                     output ready);
endinterface

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (Q1.14 by default) to unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
//   channel | dir | handshake   | word
//   mat     | in  | valid/ready | m00..m22, signed, FRAC_BITS fraction bits
//   quat    | out | valid/ready | quat_x..quat_w signed, degenerate flag
//
// One matrix per cycle sustained while the output is not stalled. The path
// is one front stage, the queue, then the back stages (square, sum, the
// one-bit-per-stage root and divide) plus the output register.
// Reset clears all valid bits; no clearing pass. A stalled output freezes the
// back pipeline; the two-word queue and front stage absorb up to three more
// words before the input is held off.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic   clk,
    input  logic   rst_n,
    mat_if.sink    mat,
    quat_if.source quat
);

    localparam int CW = rmq_pkg::comp_width(FRAC_BITS);

    logic                  f_valid;
    logic [4*CW-1:0]       f_data;
    logic                  f_take;
    logic [4*CW-1:0]       b_data;
    logic                  b_take;
    rmq_pkg::fifo_stat_t   q_stat;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat        (mat),
        .comp_valid (f_valid),
        .comp_data  (f_data),
        .comp_take  (f_take)
    );

    assign f_take = !q_stat.full;

    rmq_queue #(.WIDTH(4*CW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (f_data),
        .pop       (b_take),
        .pop_data  (b_data),
        .stat      (q_stat)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .comp_valid (!q_stat.empty),
        .comp_data  (b_data),
        .comp_take  (b_take),
        .quat       (quat)
    );

    // Queue can never be both full and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // Degenerate words carry all-zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.degenerate |->
            quat.quat_x == 0 && quat.quat_y == 0 && quat.quat_z == 0 && quat.quat_w == 0)
        else $error("degenerate word with nonzero component");

    // A full queue with a busy front stage must hold off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full && f_valid |-> !mat.ready)
        else $error("input taken while front is blocked");

endmodule

@@ hw/rtl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Classify the matrix by diagonal sign tests and form the four unnormalized
// quaternion components, held in one register stage.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = rmq_pkg::comp_width(FRAC_BITS)
) (
    input  logic                clk,
    input  logic                rst_n,
    mat_if.sink                 mat,
    output logic                comp_valid,
    output logic [4*CW-1:0]     comp_data,
    input  logic                comp_take
);

    logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [CW-1:0] one_fx;
    logic signed [CW-1:0] c0, c1, c2, c3;
    rmq_pkg::quat_case_t  sel;
    logic                 valid_reg;
    logic [4*CW-1:0]      data_reg;
    logic                 advance;

    // Widen elements so no sum wraps
    assign e00 = CW'(mat.m00);
    assign e01 = CW'(mat.m01);
    assign e02 = CW'(mat.m02);
    assign e10 = CW'(mat.m10);
    assign e11 = CW'(mat.m11);
    assign e12 = CW'(mat.m12);
    assign e20 = CW'(mat.m20);
    assign e21 = CW'(mat.m21);
    assign e22 = CW'(mat.m22);
    assign one_fx = CW'(1) <<< FRAC_BITS;

    // Pick the case from the diagonal
    always_comb
    begin
        if (e22 <= 0)
        begin
            sel = (e00 >= e11) ? rmq_pkg::CASE_X : rmq_pkg::CASE_Y;
        end
        else
        begin
            sel = (-e00 >= e11) ? rmq_pkg::CASE_Z : rmq_pkg::CASE_W;
        end
    end

    // Form the unnormalized components
    always_comb
    begin
        case (sel)
            rmq_pkg::CASE_X:
            begin
                c0 = one_fx + e00 - e11 - e22;
                c1 = e10 + e01;
                c2 = e20 + e02;
                c3 = e21 - e12;
            end
            rmq_pkg::CASE_Y:
            begin
                c0 = e10 + e01;
                c1 = one_fx - e00 + e11 - e22;
                c2 = e21 + e12;
                c3 = e02 - e20;
            end
            rmq_pkg::CASE_Z:
            begin
                c0 = e20 + e02;
                c1 = e21 + e12;
                c2 = one_fx - e00 - e11 + e22;
                c3 = e10 - e01;
            end
            default:
            begin
                c0 = e21 - e12;
                c1 = e02 - e20;
                c2 = e10 - e01;
                c3 = one_fx + e00 + e11 + e22;
            end
        endcase
    end

    // Advance when the stage is empty or the queue takes its word
    assign advance   = !valid_reg || comp_take;
    assign mat.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= mat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && mat.valid)
        begin
            data_reg <= {c3, c2, c1, c0};
        end
    end

    assign comp_valid = valid_reg;
    assign comp_data  = data_reg;

endmodule

@@ hw/rtl/rmq_queue.sv @@
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module rmq_queue #(
    parameter int WIDTH = 80
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output rmq_pkg::fifo_stat_t  stat
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // Step pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];

endmodule

@@ hw/rtl/rmq_back.sv @@
// ----------------------------------------------------------------------------
// rmq_back
// Normalize the components: square and sum, pipelined bit-by-bit square root,
// pipelined restoring divides, rounding and saturation.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = rmq_pkg::comp_width(FRAC_BITS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 comp_valid,
    input  logic [4*CW-1:0]      comp_data,
    output logic                 comp_take,
    quat_if.source               quat
);

    localparam int MW      = CW - 1;
    localparam int SQW     = 2 * MW;
    localparam int NW      = SQW + 2;
    localparam int NS      = NW / 2;
    localparam int RW      = NS;
    localparam int DW      = MW + FRAC_BITS + 1;
    localparam int QW      = FRAC_BITS + 1;
    localparam int ST_SUM  = 1;
    localparam int ST_RT0  = 2;
    localparam int ST_PREP = ST_RT0 + NS;
    localparam int ST_DV0  = ST_PREP + 1;
    localparam int NSTG    = ST_DV0 + QW;
    localparam int SW      = QW + 1;
    localparam int CLW     = (SW > 17) ? SW : 17;
    localparam int QUAT_WL = rmq_pkg::QUAT_W;

    typedef struct packed {
        logic [3:0]            neg;
        logic [3:0][MW-1:0]    mag;
        logic [3:0][SQW-1:0]   sq;
        logic [NW-1:0]         rem;
        logic [NW-1:0]         res;
        logic                  zero;
        logic [3:0][DW-1:0]    part;
        logic [3:0][QW-1:0]    quo;
    } stage_t;

    stage_t                pl_reg  [NSTG];
    stage_t                pl_next [NSTG];
    logic [NSTG-1:0]       v_reg;
    logic                  ce;
    logic                  out_valid_reg;

    logic signed [QUAT_WL-1:0] qo_next [4];
    logic signed [QUAT_WL-1:0] qo_reg  [4];
    logic                      deg_reg;

    // Whole pipeline moves unless the output word is stalled
    assign ce        = !out_valid_reg || quat.ready;
    assign comp_take = ce;

    genvar g;
    generate
        for (g = 0; g < NSTG; g++)
        begin : g_stage
            if (g == 0)
            begin : g_sq
                // Take magnitudes and square them
                always_comb
                begin
                    logic signed [CW-1:0] c;
                    pl_next[g] = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        c = comp_data[i*CW +: CW];
                        pl_next[g].neg[i] = c[CW-1];
                        pl_next[g].mag[i] = c[CW-1] ? MW'(-c) : MW'(c);
                        pl_next[g].sq[i]  = SQW'(pl_next[g].mag[i]) *
                                            SQW'(pl_next[g].mag[i]);
                    end
                end
            end
            else if (g == ST_SUM)
            begin : g_sum
                // Sum the squares into the norm
                always_comb
                begin
                    pl_next[g]      = pl_reg[g-1];
                    pl_next[g].rem  = NW'(pl_reg[g-1].sq[0]) + NW'(pl_reg[g-1].sq[1])
                                    + NW'(pl_reg[g-1].sq[2]) + NW'(pl_reg[g-1].sq[3]);
                    pl_next[g].res  = '0;
                    pl_next[g].zero = (pl_reg[g-1].mag == '0);
                end
            end
            else if (g < ST_PREP)
            begin : g_root
                // One root bit per stage
                localparam int BP = NW - 2 - 2 * (g - ST_RT0);
                always_comb
                begin
                    logic [NW:0] trial;
                    logic [NW-1:0] bitv;
                    bitv       = NW'(1) << BP;
                    trial      = {1'b0, pl_reg[g-1].res} + {1'b0, bitv};
                    pl_next[g] = pl_reg[g-1];
                    if ({1'b0, pl_reg[g-1].rem} >= trial)
                    begin
                        pl_next[g].rem = pl_reg[g-1].rem - NW'(trial);
                        pl_next[g].res = (pl_reg[g-1].res >> 1) + bitv;
                    end
                    else
                    begin
                        pl_next[g].res = pl_reg[g-1].res >> 1;
                    end
                end
            end
            else if (g == ST_PREP)
            begin : g_prep
                // Load dividends with the half-divisor rounding term
                always_comb
                begin
                    pl_next[g] = pl_reg[g-1];
                    for (int i = 0; i < 4; i++)
                    begin
                        pl_next[g].part[i] = (DW'(pl_reg[g-1].mag[i]) << FRAC_BITS)
                                           + DW'(pl_reg[g-1].res[RW-1:0] >> 1);
                        pl_next[g].quo[i]  = '0;
                    end
                end
            end
            else
            begin : g_div
                // One quotient bit per stage for each component
                localparam int QB = QW - 1 - (g - ST_DV0);
                always_comb
                begin
                    logic [DW-1:0] dvs;
                    dvs        = DW'(pl_reg[g-1].res[RW-1:0]) << QB;
                    pl_next[g] = pl_reg[g-1];
                    for (int i = 0; i < 4; i++)
                    begin
                        if (pl_reg[g-1].part[i] >= dvs)
                        begin
                            pl_next[g].part[i]    = pl_reg[g-1].part[i] - dvs;
                            pl_next[g].quo[i][QB] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (ce)
                begin
                    v_reg[g] <= (g == 0) ? comp_valid : v_reg[(g == 0) ? 0 : g-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    pl_reg[g] <= pl_next[g];
                end
            end
        end
    endgenerate

    // Clamp, apply sign, clamp to the output range, zero on degenerate
    always_comb
    begin
        logic [QW-1:0]         qm;
        logic signed [CLW-1:0] sv;
        logic signed [CLW-1:0] one_c;
        one_c = CLW'(1) <<< FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            qm = pl_reg[NSTG-1].quo[i];
            sv = CLW'({1'b0, qm});
            if (sv > one_c)
            begin
                sv = one_c;
            end
            if (pl_reg[NSTG-1].neg[i])
            begin
                sv = -sv;
            end
            if (sv > CLW'(32767))
            begin
                sv = CLW'(32767);
            end
            if (sv < -CLW'(32768))
            begin
                sv = -CLW'(32768);
            end
            qo_next[i] = pl_reg[NSTG-1].zero ? '0 : QUAT_WL'(sv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= v_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                qo_reg[i] <= qo_next[i];
            end
            deg_reg <= pl_reg[NSTG-1].zero;
        end
    end

    assign quat.valid      = out_valid_reg;
    assign quat.quat_x     = qo_reg[0];
    assign quat.quat_y     = qo_reg[1];
    assign quat.quat_z     = qo_reg[2];
    assign quat.quat_w     = qo_reg[3];
    assign quat.degenerate = deg_reg;

endmodule

@@ tb/sv/rmq_tb_if.sv @@
// ----------------------------------------------------------------------------
// rmq_tb_if
// Word types for the testbench: one matrix word as driven on the input
// channel and one quaternion word as seen on the output channel.
// ----------------------------------------------------------------------------
package rmq_tb_types;

    // One matrix word as driven on the input channel
    typedef struct {
        logic signed [rmq_pkg::ELEM_W-1:0] m00, m01, m02;
        logic signed [rmq_pkg::ELEM_W-1:0] m10, m11, m12;
        logic signed [rmq_pkg::ELEM_W-1:0] m20, m21, m22;
    } matrix_t;

    // One quaternion word as seen on the output channel
    typedef struct {
        logic signed [rmq_pkg::QUAT_W-1:0] x, y, z, w;
        logic                              degen;
    } quat_t;

endpackage

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives matrix words into the rotation matrix to quaternion block, predicts
// each quaternion word, and compares the words in order. A directed table
// covers the identity, the four case branches, extremes and ties of the case
// compares; random matrices (mostly true rotations, some with noise) follow.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 14;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int LATENCY   = 60;
    localparam int N_RANDOM  = 630;
    localparam int N_DIR     = 16;
    localparam int EW        = rmq_pkg::ELEM_W;
    localparam int QW        = rmq_pkg::QUAT_W;
    localparam logic signed [QW-1:0] UNIT_Q = QW'(ONE_FX);

    logic clk;
    logic rst_n;

    mat_if  mat ();
    quat_if quat ();

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .mat  (mat),
        .quat (quat)
    );

    rmq_tb_types::quat_t expected_quats[$];
    int      mismatches;
    bit      stim_done;
    bit      calm;          // no idling in the last part of the run
    bit      hold_off;      // long receiver stall request
    int      hold_cycles;

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hold reset, then release it
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort on a hang
    initial
    begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end

    // Integer square root, bit by bit over 64 bits
    function automatic logic [63:0] root_of(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale one component by ONE / root, round half away, clamp
    function automatic logic signed [QW-1:0] unit_comp(input longint c,
                                                       input logic [63:0] r);
        logic [63:0] mag;
        longint      q;
        mag = ((c < 0) ? -c : c) * ONE_FX;
        q   = longint'((mag + r / 2) / r);
        if (q > ONE_FX) q = ONE_FX;
        if (c < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[QW-1:0];
    endfunction

    // Predict the quaternion word for one matrix
    function automatic rmq_tb_types::quat_t quat_of(input rmq_tb_types::matrix_t m);
        longint              a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint              q[4];
        logic [63:0]         n;
        logic [63:0]         r;
        rmq_pkg::quat_case_t sel;
        rmq_tb_types::quat_t o;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        if (a22 <= 0)
            sel = (a00 >= a11) ? rmq_pkg::CASE_X : rmq_pkg::CASE_Y;
        else
            sel = (-a00 >= a11) ? rmq_pkg::CASE_Z : rmq_pkg::CASE_W;
        case (sel)
            rmq_pkg::CASE_X:
                q = '{ONE_FX + a00 - a11 - a22, a10 + a01, a20 + a02, a21 - a12};
            rmq_pkg::CASE_Y:
                q = '{a10 + a01, ONE_FX - a00 + a11 - a22, a21 + a12, a02 - a20};
            rmq_pkg::CASE_Z:
                q = '{a20 + a02, a21 + a12, ONE_FX - a00 - a11 + a22, a10 - a01};
            default:
                q = '{a21 - a12, a02 - a20, a10 - a01, ONE_FX + a00 + a11 + a22};
        endcase
        n = 0;
        for (int i = 0; i < 4; i++)
            n += q[i] * q[i];
        if (n == 0)
        begin
            o = '{x: '0, y: '0, z: '0, w: '0, degen: 1'b1};
            return o;
        end
        r = root_of(n);
        o.x = unit_comp(q[0], r);
        o.y = unit_comp(q[1], r);
        o.z = unit_comp(q[2], r);
        o.w = unit_comp(q[3], r);
        o.degen = 1'b0;
        return o;
    endfunction

    function automatic rmq_tb_types::matrix_t mk(input int a, b, c, d, e, f, g, h, i);
        rmq_tb_types::matrix_t m;
        m.m00 = EW'(a); m.m01 = EW'(b); m.m02 = EW'(c);
        m.m10 = EW'(d); m.m11 = EW'(e); m.m12 = EW'(f);
        m.m20 = EW'(g); m.m21 = EW'(h); m.m22 = EW'(i);
        return m;
    endfunction

    // Random matrix: mostly a rotation built from a random quaternion, else random elements
    function automatic rmq_tb_types::matrix_t random_matrix();
        rmq_tb_types::matrix_t m;
        int      kind;
        real     qw, qx, qy, qz, s;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            m = mk($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
            return m;
        end
        qw = $urandom_range(0, 2000) - 1000.0;
        qx = $urandom_range(0, 2000) - 1000.0;
        qy = $urandom_range(0, 2000) - 1000.0;
        qz = $urandom_range(0, 2000) - 1000.0;
        s  = qw * qw + qx * qx + qy * qy + qz * qz;
        if (s < 1.0) s = 1.0;
        s = 2.0 * ONE_FX / s;
        m = mk(int'(ONE_FX - s * (qy * qy + qz * qz)), int'(s * (qx * qy - qz * qw)),
               int'(s * (qx * qz + qy * qw)), int'(s * (qx * qy + qz * qw)),
               int'(ONE_FX - s * (qx * qx + qz * qz)), int'(s * (qy * qz - qx * qw)),
               int'(s * (qx * qz - qy * qw)), int'(s * (qy * qz + qx * qw)),
               int'(ONE_FX - s * (qx * qx + qy * qy)));
        // add a little noise to m11 in some of them
        if (kind == 9)
            m.m11 = EW'(int'(m.m11) + int'($urandom_range(0, 64)) - 32);
        return m;
    endfunction

    // Directed table: matrix plus optional typed-in expectation
    rmq_tb_types::matrix_t dir_mat[N_DIR];
    rmq_tb_types::quat_t   dir_exp[N_DIR];
    bit                    dir_has[N_DIR];

    initial
    begin
        dir_has = '{default: 1'b0};
        // identity: w case, unit w
        dir_mat[0]  = mk(ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, ONE_FX);
        dir_exp[0]  = '{x: '0, y: '0, z: '0, w: UNIT_Q, degen: 1'b0};
        dir_has[0]  = 1'b1;
        // half turn about x: x case
        dir_mat[1]  = mk(ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, -ONE_FX);
        dir_exp[1]  = '{x: UNIT_Q, y: '0, z: '0, w: '0, degen: 1'b0};
        dir_has[1]  = 1'b1;
        // half turn about y: y case
        dir_mat[2]  = mk(-ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, -ONE_FX);
        dir_exp[2]  = '{x: '0, y: UNIT_Q, z: '0, w: '0, degen: 1'b0};
        dir_has[2]  = 1'b1;
        // half turn about z: z case
        dir_mat[3]  = mk(-ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, ONE_FX);
        dir_exp[3]  = '{x: '0, y: '0, z: UNIT_Q, w: '0, degen: 1'b0};
        dir_has[3]  = 1'b1;
        // z case on a tie of -m00 and m11
        dir_mat[4]  = mk(0, 0, 0, 0, 0, 0, 0, 0, ONE_FX);
        // off-diagonal terms in the z and y cases
        dir_mat[5]  = mk(-ONE_FX, 5, -7, 5, 0, 3, 7, 3, 1);
        dir_mat[6]  = mk(-ONE_FX - 3, 9, 4, 9, 4, 0, 4, 0, -1);
        // unequal diagonal, pure z: unit z
        dir_mat[7]  = mk(-2 * ONE_FX, 0, 0, 0, ONE_FX / 2 + 1, 0, 0, 0, ONE_FX / 2 - 1);
        dir_exp[7]  = '{x: '0, y: '0, z: UNIT_Q, w: '0, degen: 1'b0};
        dir_has[7]  = 1'b1;
        // extremes of every field
        dir_mat[8]  = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768);
        dir_mat[9]  = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        dir_mat[10] = mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 0);
        dir_mat[11] = mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 1);
        dir_mat[12] = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        // ties of the case compares
        dir_mat[13] = mk(100, 3, 4, 5, 100, 6, 7, 8, 0);
        dir_mat[14] = mk(-200, 3, 4, 5, 200, 6, 7, 8, 1);
        dir_mat[15] = mk(-1, 32767, -32768, 1, -1, -32768, 32767, 1, -1);
    end

    // Offer matrix words, idling in bursts
    initial
    begin
        rmq_tb_types::matrix_t m;
        int      total;
        int      idle;
        mat.valid <= 1'b0;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
         mat.m20, mat.m21, mat.m22} <= '0;
        stim_done = 1'b0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        total     = N_DIR + N_RANDOM;
        @(posedge rst_n);
        @(posedge clk);
        for (int k = 0; k < total; k++)
        begin
            m = (k < N_DIR) ? dir_mat[k] : random_matrix();
            // long receiver stall while words keep coming
            if (k == 100)
                hold_off = 1'b1;
            // drain completely once before continuing
            if (k == 300)
            begin
                mat.valid <= 1'b0;
                while (expected_quats.size() != 0)
                    @(posedge clk);
            end
            if (k == total - 80)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                idle = $urandom_range(1, 13);
                mat.valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            mat.valid <= 1'b1;
            mat.m00 <= m.m00; mat.m01 <= m.m01; mat.m02 <= m.m02;
            mat.m10 <= m.m10; mat.m11 <= m.m11; mat.m12 <= m.m12;
            mat.m20 <= m.m20; mat.m21 <= m.m21; mat.m22 <= m.m22;
            // hold until accepted
            do
                @(posedge clk);
            while (!mat.ready);
            if (k < N_DIR && dir_has[k])
                expected_quats.push_back(dir_exp[k]);
            else
                expected_quats.push_back(quat_of(m));
        end
        mat.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Count out the long receiver stall
    initial
    begin
        hold_cycles = 0;
        wait (hold_off);
        while (hold_cycles < 150)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_off = 1'b0;
    end

    // Accept quaternion words with random stalls
    initial
    begin
        int idle;
        quat.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                quat.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                idle = $urandom_range(1, 13);
                quat.ready <= 1'b0;
                repeat (idle - 1) @(posedge clk);
            end
            else
                quat.ready <= 1'b1;
        end
    end

    // Compare each quaternion word with the oldest prediction
    always @(posedge clk)
    begin
        rmq_tb_types::quat_t exp_q;
        if (rst_n && quat.valid && quat.ready)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected quaternion word x=%0d y=%0d z=%0d w=%0d",
                             quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w);
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                if (quat.quat_x !== exp_q.x || quat.quat_y !== exp_q.y ||
                    quat.quat_z !== exp_q.z || quat.quat_w !== exp_q.w ||
                    quat.degenerate !== exp_q.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch exp %0d %0d %0d %0d d=%0b got %0d %0d %0d %0d d=%0b",
                                 exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.degen,
                                 quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w,
                                 quat.degenerate);
                end
            end
        end
    end

    // Wait for the drain, then report
    initial
    begin
        mismatches = 0;
        wait (stim_done);
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_quats.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_if.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_queue.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/sv/rmq_tb_if.sv
tb/sv/tb.sv
